FILE: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: sv/pbp_pkg.sv
// types, codes and constants of the pushbuffer method stream parser
package pbp_pkg;

  // default clamp on the buffer length in words
  localparam int MAX_WORDS_DEFAULT = 512;

  // field widths
  localparam int WORD_W   = 32;
  localparam int LEN_W    = 10;
  localparam int COUNT_W  = 13;
  localparam int METHOD_W = 14;
  localparam int OFFS_W   = 11;

  // word kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_STOP    = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // payload classes
  localparam logic [1:0] PAY_NONE   = 2'd0;
  localparam logic [1:0] PAY_INLINE = 2'd1;
  localparam logic [1:0] PAY_QMD    = 2'd2;
  localparam logic [1:0] PAY_SHORT  = 2'd3;

  // opcodes
  localparam logic [2:0] OP_INCR      = 3'd1;
  localparam logic [2:0] OP_NONINCR   = 3'd3;
  localparam logic [2:0] OP_IMMEDIATE = 3'd4;
  localparam logic [2:0] OP_ONEINCR   = 3'd5;

  // special methods and thresholds
  localparam logic [METHOD_W-1:0] METHOD_INLINE = 14'h01b4;
  localparam logic [METHOD_W-1:0] METHOD_QMD_A  = 14'h0320;
  localparam logic [METHOD_W-1:0] METHOD_QMD_B  = 14'h0318;
  localparam logic [COUNT_W-1:0]  LONG_RUN_MIN  = 13'h0020;
  localparam logic [COUNT_W-1:0]  SHORT_RUN_MAX = 13'd6;

  // input item
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              first_word;
    logic [LEN_W-1:0]  buffer_length;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0]          word_kind;
    logic [2:0]          opcode;
    logic [2:0]          subchannel;
    logic [METHOD_W-1:0] method_address;
    logic [COUNT_W-1:0]  run_count;
    logic [COUNT_W-1:0]  data_index;
    logic [1:0]          payload_kind;
    logic [OFFS_W-1:0]   byte_offset;
    logic [WORD_W-1:0]   data_value;
  } out_item_t;

  // fields of the header that owns the current run
  typedef struct packed {
    logic [2:0]          opcode;
    logic [2:0]          subchannel;
    logic [METHOD_W-1:0] method;
    logic [COUNT_W-1:0]  count;
    logic [1:0]          payload;
  } hdr_t;

  // walk state
  typedef struct packed {
    logic [COUNT_W-1:0] remaining;
    logic [LEN_W-1:0]   position;
    logic [LEN_W-1:0]   limit;
    logic               stopped;
    hdr_t               held;
    logic [COUNT_W-1:0] run_index;
  } pbp_state_t;

  localparam pbp_state_t STATE_RESET = '{
    remaining: '0, position: '0, limit: '0, stopped: 1'b1, held: '0, run_index: '0
  };

endpackage

FILE: sv/pushbuffer_method_stream_parser_core.sv
// top level of the pushbuffer method stream parser
//
//   channel  valid      stall      payload
//   -------  ---------  ---------  ----------------------
//   src      src_valid  src_stall  src_item (in_item_t)
//   dst      dst_valid  dst_stall  dst_item (out_item_t)
//
// one word per cycle while src_stall is low; the result of each transfer is registered
// the walk state updates in the cycle of the transfer, from a single decode stage
// a two-entry output (result register plus skid) keeps src moving while dst stalls
// src_stall rises only once both entries hold results
// rst (synchronous) stops the walk until the next first word and empties the output
module pushbuffer_method_stream_parser_core
  import pbp_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_item_t  src_item,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_item_t dst_item
);

  pbp_state_t st;
  pbp_state_t st_next;
  out_item_t  step_res;
  out_item_t  skid_item;
  logic       skid_valid;
  logic       src_take;
  logic       main_free;

  pbp_step #(
    .MAX_WORDS (MAX_WORDS)
  ) u_step (
    .item (src_item),
    .cur  (st),
    .nxt  (st_next),
    .res  (step_res)
  );

  assign src_stall = skid_valid;
  assign src_take  = src_valid && !skid_valid;
  assign main_free = !dst_valid || !dst_stall;

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (src_take) begin
      st <= st_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      dst_valid  <= skid_valid || src_take;
      skid_valid <= 1'b0;
    end else if (src_take) begin
      skid_valid <= 1'b1;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (main_free) begin
      dst_item <= skid_valid ? skid_item : step_res;
    end
    if (!main_free && src_take) begin
      skid_item <= step_res;
    end
  end

endmodule

FILE: sv/pbp_step.sv
// word classification and next walk state for one command word
module pbp_step
  import pbp_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEFAULT
) (
  input  in_item_t   item,
  input  pbp_state_t cur,
  output pbp_state_t nxt,
  output out_item_t  res
);

  pbp_state_t          eff;
  hdr_t                hdr;
  logic [COUNT_W-1:0]  nd;
  logic                run_op;
  logic                stop_op;
  logic [COUNT_W:0]    span;
  logic                overrun;
  logic [1:0]          pclass;
  logic [LEN_W+1:0]    offs_wide;
  logic [COUNT_W-1:0]  len_wide;

  // a first word restarts the walk before anything else
  always_comb begin
    len_wide = COUNT_W'(item.buffer_length);
    eff      = cur;
    if (item.first_word) begin
      eff.limit     = (len_wide > COUNT_W'(MAX_WORDS)) ? LEN_W'(MAX_WORDS)
                                                       : item.buffer_length;
      eff.position  = '0;
      eff.stopped   = 1'b0;
      eff.remaining = '0;
      eff.run_index = '0;
      eff.held      = '0;
    end
  end

  // header split and run length
  always_comb begin
    hdr.opcode     = item.word[31:29];
    hdr.count      = item.word[28:16];
    hdr.subchannel = item.word[15:13];
    hdr.method     = {item.word[11:0], 2'b00};
    hdr.payload    = PAY_NONE;
    run_op  = (hdr.opcode == OP_INCR) || (hdr.opcode == OP_NONINCR) ||
              (hdr.opcode == OP_ONEINCR);
    stop_op = !run_op && (hdr.opcode != OP_IMMEDIATE);
    nd      = run_op ? hdr.count : '0;
    span    = (COUNT_W+1)'(eff.position) + (COUNT_W+1)'(1) + (COUNT_W+1)'(nd);
    overrun = span > (COUNT_W+1)'(eff.limit);
  end

  // payload class of a run that opens here
  always_comb begin
    if (nd == '0) begin
      pclass = PAY_NONE;
    end else if (hdr.method == METHOD_INLINE && hdr.count >= LONG_RUN_MIN) begin
      pclass = PAY_INLINE;
    end else if ((hdr.method == METHOD_QMD_A || hdr.method == METHOD_QMD_B) &&
                 hdr.count >= LONG_RUN_MIN) begin
      pclass = PAY_QMD;
    end else if (nd <= SHORT_RUN_MAX) begin
      pclass = PAY_SHORT;
    end else begin
      pclass = PAY_NONE;
    end
  end

  assign offs_wide = {eff.position, 2'b00};

  // classify the word and step the walk
  always_comb begin
    nxt                = eff;
    res.word_kind      = KIND_IGNORED;
    res.opcode         = '0;
    res.subchannel     = '0;
    res.method_address = '0;
    res.run_count      = '0;
    res.data_index     = '0;
    res.payload_kind   = PAY_NONE;
    res.byte_offset    = '0;
    res.data_value     = item.word;
    if (eff.stopped || eff.position >= eff.limit) begin
      // ignored: nothing moves
    end else if (eff.remaining != '0) begin
      // data word of the held run
      res.word_kind      = KIND_DATA;
      res.opcode         = eff.held.opcode;
      res.subchannel     = eff.held.subchannel;
      res.method_address = eff.held.method;
      res.run_count      = eff.held.count;
      res.data_index     = eff.run_index;
      res.payload_kind   = eff.held.payload;
      res.byte_offset    = offs_wide[OFFS_W-1:0];
      nxt.run_index      = eff.run_index + COUNT_W'(1);
      nxt.remaining      = eff.remaining - COUNT_W'(1);
      nxt.position       = eff.position + LEN_W'(1);
    end else begin
      res.opcode         = hdr.opcode;
      res.subchannel     = hdr.subchannel;
      res.method_address = hdr.method;
      res.run_count      = hdr.count;
      res.byte_offset    = offs_wide[OFFS_W-1:0];
      if (stop_op || overrun) begin
        // bad opcode or run past the end
        res.word_kind = KIND_STOP;
        nxt.stopped   = 1'b1;
      end else begin
        res.word_kind    = KIND_HEADER;
        res.payload_kind = pclass;
        nxt.held         = '{opcode: hdr.opcode, subchannel: hdr.subchannel,
                             method: hdr.method, count: hdr.count, payload: pclass};
        nxt.remaining    = nd;
        nxt.run_index    = '0;
        nxt.position     = eff.position + LEN_W'(1);
      end
    end
  end

endmodule

FILE: sv/pbp_checker.sv
// port checks on the parser top level, bound in below
`include "assert_macros.svh"

module pbp_checker
  import pbp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      src_valid,
  input logic      src_stall,
  input in_item_t  src_item,
  input logic      dst_valid,
  input logic      dst_stall,
  input out_item_t dst_item
);

  logic ignored_clear;
  logic header_slot;

  // fields that an ignored word leaves at zero
  assign ignored_clear = dst_item.opcode == '0 && dst_item.run_count == '0 &&
                         dst_item.method_address == '0 && dst_item.byte_offset == '0 &&
                         dst_item.payload_kind == PAY_NONE;

  // header or stop header on the result side
  assign header_slot = dst_valid && (dst_item.word_kind == KIND_STOP ||
                                     dst_item.word_kind == KIND_HEADER);

  // a stalled word stays offered unchanged
  `ASSERT_NEXT(a_src_hold, clk, rst, src_valid && src_stall, src_valid && $stable(src_item))

  // a stalled result stays put
  `ASSERT_NEXT(a_dst_hold, clk, rst, dst_valid && dst_stall, dst_valid && $stable(dst_item))

  // back-pressure only after the result side has stalled
  `ASSERT_IMPLIES(a_stall_cause, clk, rst, $rose(src_stall), $past(dst_valid && dst_stall))

  // ignored words carry only the word itself
  `ASSERT_IMPLIES(a_ignored_clear, clk, rst, dst_valid && dst_item.word_kind == KIND_IGNORED, ignored_clear)

  // stop headers and plain headers sit at run index zero
  `ASSERT_IMPLIES(a_header_index, clk, rst, header_slot, dst_item.data_index == '0)

endmodule

bind pushbuffer_method_stream_parser_core pbp_checker u_pbp_checker (.*);
